// ===== sv/lee_pkg.sv =====
// Shared types and constants of the line editing echo buffer.
// Holds the command and status structs that join controller and datapath.
// Depends on nothing.
package lee_pkg;

   // Default length of one line store in bytes.
   localparam int LEE_LINE_BYTES = 64;

   // Result channel codes.
   localparam logic [1:0] CH_ECHO  = 2'd0;
   localparam logic [1:0] CH_LINE  = 2'd1;
   localparam logic [1:0] CH_NONE  = 2'd2;
   localparam logic [1:0] CH_EMPTY = 2'd3;

   // Input item kinds.
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TAKE = 1'b1;

   // Terminal control characters.
   localparam logic [7:0] BYTE_BS  = 8'h08;
   localparam logic [7:0] BYTE_LF  = 8'h0A;
   localparam logic [7:0] BYTE_CR  = 8'h0D;
   localparam logic [7:0] BYTE_SP  = 8'h20;
   localparam logic [7:0] BYTE_DEL = 8'h7F;

   // What the output register is loaded with.
   typedef enum logic [2:0] {
      EMIT_RX,
      EMIT_BS,
      EMIT_SP,
      EMIT_CR,
      EMIT_LF,
      EMIT_LINE,
      EMIT_NONE,
      EMIT_EMPTY
   } lee_emit_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         load;
      logic         store;
      logic         dec_edit;
      logic         commit;
      logic         clear_wait;
      logic         rd_start;
      logic         rd;
      logic         rd_next;
      logic         emit;
      lee_emit_type emit_sel;
      logic         emit_last;
   } lee_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_take;
      logic is_lf;
      logic is_erase;
      logic is_cr;
      logic edit_empty;
      logic edit_full;
      logic waiting;
      logic held_empty;
      logic rd_last;
      logic out_free;
   } lee_stat_type;

endpackage

// ===== sv/lee_ifs.sv =====
// Handshake channels of the line editing echo buffer: request and response.
// Each carries valid, ready and the item payload. No dependencies.
interface lee_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] rx_byte;

   modport source (output valid, output kind, output rx_byte, input ready);
   modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface lee_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] channel;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output channel, output out_byte, output last, input ready);
   modport sink (input valid, input channel, input out_byte, input last, output ready);
endinterface

// ===== sv/lee_datapath.sv =====
// Datapath of the line editing echo buffer: line memory, counts and the
// output register. Acts on commands from lee_ctrl; uses lee_pkg.
module lee_datapath
   import lee_pkg::*;
#(
   parameter int LINE_BYTES = LEE_LINE_BYTES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_kind,
   input  logic [7:0]   req_rx_byte,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output logic [1:0]   rsp_channel,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_last,
   input  lee_cmd_type  cmd,
   output lee_stat_type stat
);

   localparam int CW        = $clog2(LINE_BYTES);
   localparam int MEM_DEPTH = 2 * (2 ** CW);

   // Both lines share one memory; the bank bit says which half is edited.
   logic [7:0]    mem [MEM_DEPTH];
   logic [7:0]    rd_data_ff;

   logic          item_kind_ff;
   logic [7:0]    item_byte_ff;
   logic [CW-1:0] edit_count_ff;
   logic [CW-1:0] held_count_ff;
   logic          waiting_ff;
   logic          edit_bank_ff;
   logic [CW-1:0] rd_idx_ff;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_channel_ff;
   logic [7:0]    rsp_byte_ff;
   logic          rsp_last_ff;

   logic [1:0]    emit_channel_in;
   logic [7:0]    emit_byte_in;

   // Latch the accepted item.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_kind_ff <= req_kind;
         item_byte_ff <= req_rx_byte;
      end
   end

   // Memory: write into the edit half, read from the held half.
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         mem[{edit_bank_ff, edit_count_ff}] <= item_byte_ff;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[{~edit_bank_ff, rd_idx_ff}];
      end
   end

   // Read index for streaming out the held line.
   always_ff @(posedge clock) begin
      if (cmd.rd_start) begin
         rd_idx_ff <= '0;
      end else if (cmd.rd_next) begin
         rd_idx_ff <= rd_idx_ff + 1'b1;
      end
   end

   // Counts, waiting mark and bank select. A commit with no line waiting
   // swaps the halves instead of copying the line.
   always_ff @(posedge clock) begin
      if (reset) begin
         edit_count_ff <= '0;
         held_count_ff <= '0;
         waiting_ff    <= 1'b0;
         edit_bank_ff  <= 1'b0;
      end else begin
         if (cmd.store) begin
            edit_count_ff <= edit_count_ff + 1'b1;
         end else if (cmd.dec_edit) begin
            edit_count_ff <= edit_count_ff - 1'b1;
         end else if (cmd.commit) begin
            edit_count_ff <= '0;
            if (!waiting_ff) begin
               held_count_ff <= edit_count_ff;
               edit_bank_ff  <= ~edit_bank_ff;
               waiting_ff    <= 1'b1;
            end
         end
         if (cmd.clear_wait) begin
            waiting_ff <= 1'b0;
         end
      end
   end

   // Select the result payload.
   always_comb begin
      emit_channel_in = CH_ECHO;
      emit_byte_in    = 8'd0;
      case (cmd.emit_sel)
         EMIT_RX:    emit_byte_in = item_byte_ff;
         EMIT_BS:    emit_byte_in = BYTE_BS;
         EMIT_SP:    emit_byte_in = BYTE_SP;
         EMIT_CR:    emit_byte_in = BYTE_CR;
         EMIT_LF:    emit_byte_in = BYTE_LF;
         EMIT_LINE: begin
            emit_channel_in = CH_LINE;
            emit_byte_in    = rd_data_ff;
         end
         EMIT_NONE:  emit_channel_in = CH_NONE;
         EMIT_EMPTY: emit_channel_in = CH_EMPTY;
         default:    emit_channel_in = CH_ECHO;
      endcase
   end

   // Output register; it frees up in the cycle its item is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_channel_ff <= emit_channel_in;
         rsp_byte_ff    <= emit_byte_in;
         rsp_last_ff    <= cmd.emit_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_channel  = rsp_channel_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   // Status for the controller.
   always_comb begin
      stat.is_take    = (item_kind_ff == KIND_TAKE);
      stat.is_lf      = (item_byte_ff == BYTE_LF);
      stat.is_erase   = (item_byte_ff == BYTE_BS) || (item_byte_ff == BYTE_DEL);
      stat.is_cr      = (item_byte_ff == BYTE_CR);
      stat.edit_empty = (edit_count_ff == '0);
      stat.edit_full  = (edit_count_ff == CW'(LINE_BYTES - 1));
      stat.waiting    = waiting_ff;
      stat.held_empty = (held_count_ff == '0);
      stat.rd_last    = (rd_idx_ff == held_count_ff - 1'b1);
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // The edit line never grows past its room.
   a_edit_bound: assert property (@(posedge clock) disable iff (reset)
      edit_count_ff <= CW'(LINE_BYTES - 1))
      else $error("edit count beyond line room");

   // A new result is loaded only when the output register is free.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrites a pending item");

   // Status results carry a zero byte.
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_channel_ff == CH_NONE || rsp_channel_ff == CH_EMPTY)
      |-> rsp_byte_ff == 8'd0)
      else $error("status result with nonzero byte");

   // A commit with no line waiting leaves a line waiting.
   a_commit_wait: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && !waiting_ff |=> waiting_ff)
      else $error("commit did not mark a waiting line");

endmodule

// ===== sv/lee_ctrl.sv =====
// Controller of the line editing echo buffer: decodes each item and
// sequences echoes and line read-out. Uses lee_pkg; drives lee_datapath.
module lee_ctrl
   import lee_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  lee_stat_type stat,
   output lee_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ERASE,
      ST_CRLF,
      ST_ECHO,
      ST_REPLY,
      ST_LINE_RD,
      ST_LINE_EMIT
   } state_type;

   state_type    state_ff, state_in;
   logic [1:0]   step_ff, step_in;
   lee_emit_type reply_ff, reply_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      reply_in = reply_ff;
      cmd      = '0;
      cmd.emit_sel = EMIT_RX;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            step_in  = 2'd0;
            state_in = ST_IDLE;
            if (stat.is_take) begin
               if (!stat.waiting) begin
                  reply_in = EMIT_NONE;
                  state_in = ST_REPLY;
               end else if (stat.held_empty) begin
                  cmd.clear_wait = 1'b1;
                  reply_in       = EMIT_EMPTY;
                  state_in       = ST_REPLY;
               end else begin
                  cmd.clear_wait = 1'b1;
                  cmd.rd_start   = 1'b1;
                  state_in       = ST_LINE_RD;
               end
            end else if (stat.is_lf) begin
               state_in = ST_IDLE;
            end else if (stat.is_erase) begin
               if (!stat.edit_empty) begin
                  cmd.dec_edit = 1'b1;
                  state_in     = ST_ERASE;
               end
            end else if (stat.is_cr) begin
               cmd.commit = 1'b1;
               state_in   = ST_CRLF;
            end else if (!stat.edit_full) begin
               cmd.store = 1'b1;
               state_in  = ST_ECHO;
            end
         end
         // Backspace, space, backspace.
         ST_ERASE: begin
            cmd.emit_sel  = (step_ff == 2'd1) ? EMIT_SP : EMIT_BS;
            cmd.emit_last = (step_ff == 2'd2);
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               step_in  = step_ff + 2'd1;
               if (step_ff == 2'd2) begin
                  state_in = ST_IDLE;
               end
            end
         end
         // Carriage return, line feed.
         ST_CRLF: begin
            cmd.emit_sel  = (step_ff == 2'd0) ? EMIT_CR : EMIT_LF;
            cmd.emit_last = (step_ff == 2'd1);
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               step_in  = step_ff + 2'd1;
               if (step_ff == 2'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ECHO: begin
            cmd.emit_sel  = EMIT_RX;
            cmd.emit_last = 1'b1;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_REPLY: begin
            cmd.emit_sel  = reply_ff;
            cmd.emit_last = 1'b1;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_LINE_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_LINE_EMIT;
         end
         ST_LINE_EMIT: begin
            cmd.emit_sel  = EMIT_LINE;
            cmd.emit_last = stat.rd_last;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.rd_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
                  state_in    = ST_LINE_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 2'd0;
         reply_ff <= EMIT_NONE;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         reply_ff <= reply_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

// ===== sv/line_editing_echo_buffer_core.sv =====
// Top level of the line editing echo buffer.
// Joins lee_ctrl and lee_datapath to the request and response channels.
// Uses lee_pkg and the channel interfaces in lee_ifs.sv.

// Terminal line editor for received bytes. Each request item is either a
// received byte or a take request; the response items are echo bytes, the
// bytes of the held line, or one status item, and the final response of
// each request has last set. Items are handled one at a time: a request
// is accepted, decoded in the next cycle, and then its responses go out
// in order, each loaded once the output register is free, so the response
// side can stall them. A line feed, a dropped byte or an erase on an empty
// line gives no response. Read-out of a held line reads each byte through
// the registered read port of the line memory before it is emitted. The
// edit line and the held line are two halves of one memory; a carriage
// return with no line waiting swaps the halves, so no copy time is spent.
// A line holds at most LINE_BYTES-1 bytes. No clearing pass is needed after reset.
module line_editing_echo_buffer_core
   import lee_pkg::*;
#(
   parameter int LINE_BYTES = LEE_LINE_BYTES
) (
   input  logic      clock,
   input  logic      reset,
   lee_req_if.sink   req_chan,
   lee_rsp_if.source rsp_chan
);

   lee_cmd_type  cmd;
   lee_stat_type stat;

   // Sequencing of each item.
   lee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Line memory, counts and output register.
   lee_datapath #(
      .LINE_BYTES (LINE_BYTES)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_kind     (req_chan.kind),
      .req_rx_byte  (req_chan.rx_byte),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .rsp_channel  (rsp_chan.channel),
      .rsp_out_byte (rsp_chan.out_byte),
      .rsp_last     (rsp_chan.last),
      .cmd          (cmd),
      .stat         (stat)
   );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the line editing echo buffer core.
// Drives received bytes and take requests, predicts echoes and line read-outs.
// Depends on lee_pkg, the channel interfaces and line_editing_echo_buffer_core.
module tb;
   import lee_pkg::*;

   localparam int LINE_LEN = LEE_LINE_BYTES;

   // One request item waiting to be offered, with its lead-in gap.
   typedef struct {
      logic       kind;
      logic [7:0] data;
      int         gap;
      bit         drain;
   } typed_item_type;

   // One response item as the block should emit it.
   typedef struct {
      logic [1:0] channel;
      logic [7:0] out_byte;
      logic       last;
   } term_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lee_req_if req_if ();
   lee_rsp_if rsp_if ();

   line_editing_echo_buffer_core #(
      .LINE_BYTES(LINE_LEN)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   // Stimulus and expectation stores.
   typed_item_type typed_q[$];
   term_out_type   due_rsp[$];

   // Shadow state of the line editor.
   logic [7:0] edit_buf[LINE_LEN];
   logic [7:0] held_buf[LINE_LEN];
   int         edit_len = 0;
   int         held_len = 0;
   bit         line_held = 1'b0;

   // Bookkeeping.
   int err_count = 0;
   int n_req_acc = 0;
   int n_rsp_acc = 0;
   int n_takes = 0;
   int n_lines_out = 0;
   int n_erases = 0;
   int n_dropped = 0;
   int quiet = 0;
   bit req_done = 1'b0;

   // Clock.
   always #1 clock = ~clock;

   // Reset and known input levels from time zero.
   initial begin
      req_if.valid = 1'b0;
      req_if.kind = KIND_BYTE;
      req_if.rx_byte = 8'h00;
      rsp_if.ready = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Prints one mismatch line and counts it.
   task automatic flag_error(string msg);
      err_count++;
      if (err_count <= 40) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endtask

   // Applies one request item to the shadow state and queues the responses it causes.
   function automatic void edit_and_emit(logic kind, logic [7:0] b);
      term_out_type outs[$];
      int i;
      if (kind == KIND_TAKE) begin
         n_takes++;
         if (!line_held) begin
            outs.push_back('{CH_NONE, 8'h00, 1'b0});
         end else if (held_len == 0) begin
            line_held = 1'b0;
            outs.push_back('{CH_EMPTY, 8'h00, 1'b0});
         end else begin
            line_held = 1'b0;
            n_lines_out++;
            for (i = 0; i < held_len; i++) begin
               outs.push_back('{CH_LINE, held_buf[i], 1'b0});
            end
         end
      end else if (b == BYTE_LF) begin
         // A line feed is ignored outright.
      end else if (b == BYTE_BS || b == BYTE_DEL) begin
         if (edit_len > 0) begin
            edit_len--;
            n_erases++;
            outs.push_back('{CH_ECHO, BYTE_BS, 1'b0});
            outs.push_back('{CH_ECHO, BYTE_SP, 1'b0});
            outs.push_back('{CH_ECHO, BYTE_BS, 1'b0});
         end
      end else if (b == BYTE_CR) begin
         // The edit line only moves over when the holding store is free.
         if (!line_held) begin
            held_buf = edit_buf;
            held_len = edit_len;
            line_held = 1'b1;
         end
         edit_len = 0;
         outs.push_back('{CH_ECHO, BYTE_CR, 1'b0});
         outs.push_back('{CH_ECHO, BYTE_LF, 1'b0});
      end else if (edit_len < LINE_LEN - 1) begin
         edit_buf[edit_len] = b;
         edit_len++;
         outs.push_back('{CH_ECHO, b, 1'b0});
      end else begin
         n_dropped++;
      end
      if (outs.size() > 0) begin
         outs[outs.size() - 1].last = 1'b1;
      end
      foreach (outs[k]) begin
         due_rsp.push_back(outs[k]);
      end
   endfunction

   // Sender gap: mostly none, some short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         return 0;
      end else if (r < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Random byte that is not a control character the editor acts on.
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (b == BYTE_LF || b == BYTE_CR || b == BYTE_BS || b == BYTE_DEL) begin
         b = 8'($urandom_range(0, 255));
      end
      return b;
   endfunction

   function automatic void push_item(logic kind, logic [7:0] data, int gap, bit drain);
      typed_q.push_back('{kind, data, gap, drain});
   endfunction

   // Driver: offers queued items at the falling edge, holding each until taken.
   typed_item_type cur;
   bit             have_cur = 1'b0;
   int             wait_cnt = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!(req_if.valid && !req_done)) begin
         if (!have_cur && typed_q.size() > 0) begin
            cur = typed_q.pop_front();
            have_cur = 1'b1;
            wait_cnt = cur.gap;
         end
         if (have_cur && wait_cnt > 0) begin
            wait_cnt--;
            req_if.valid <= 1'b0;
         end else if (have_cur && cur.drain && (due_rsp.size() != 0 || quiet < 8)) begin
            req_if.valid <= 1'b0;
         end else if (have_cur) begin
            req_if.valid <= 1'b1;
            req_if.kind <= cur.kind;
            req_if.rx_byte <= cur.data;
            have_cur = 1'b0;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, one long hold-off, and a calm stretch.
   int  hold_cnt = 0;
   bit  long_done = 1'b0;

   always @(negedge clock) begin
      int r;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_if.ready <= 1'b0;
      end else if (!long_done && n_req_acc >= 40) begin
         long_done = 1'b1;
         hold_cnt = 300;
         rsp_if.ready <= 1'b0;
      end else if (n_req_acc >= 60 && n_req_acc < 90) begin
         rsp_if.ready <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            rsp_if.ready <= 1'b1;
         end else if (r < 97) begin
            hold_cnt = $urandom_range(0, 3);
            rsp_if.ready <= 1'b0;
         end else begin
            hold_cnt = $urandom_range(20, 60);
            rsp_if.ready <= 1'b0;
         end
      end
   end

   // Monitor: checks responses against the oldest expectation, then predicts new requests.
   always @(posedge clock) begin
      term_out_type exp_out;
      req_done <= !reset && req_if.valid && req_if.ready;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            n_rsp_acc++;
            if (due_rsp.size() == 0) begin
               flag_error($sformatf("unexpected response ch=%0d byte=%02h last=%0b",
                  rsp_if.channel, rsp_if.out_byte, rsp_if.last));
            end else begin
               exp_out = due_rsp.pop_front();
               if (rsp_if.channel !== exp_out.channel || rsp_if.out_byte !== exp_out.out_byte
                   || rsp_if.last !== exp_out.last) begin
                  flag_error($sformatf(
                     "response %0d: got ch=%0d byte=%02h last=%0b, want ch=%0d byte=%02h last=%0b",
                     n_rsp_acc, rsp_if.channel, rsp_if.out_byte, rsp_if.last,
                     exp_out.channel, exp_out.out_byte, exp_out.last));
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            n_req_acc++;
            edit_and_emit(req_if.kind, req_if.rx_byte);
         end
         // Idle time since the last handshake with nothing owed.
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
             || due_rsp.size() != 0) begin
            quiet = 0;
         end else if (quiet < 1000) begin
            quiet++;
         end
      end
   end

   // Stimulus: directed cases, then random lines with noise, then wrap-up.
   initial begin
      int n_rand;
      int len;
      int r;
      int n_total;
      bit long_sent;
      int i;

      // Directed part.
      push_item(KIND_TAKE, 8'h00, 0, 1'b0);      // take with nothing waiting
      push_item(KIND_BYTE, BYTE_BS, 0, 1'b0);    // erase on an empty line
      push_item(KIND_BYTE, BYTE_DEL, 0, 1'b0);
      push_item(KIND_BYTE, BYTE_LF, 0, 1'b0);    // line feed is ignored
      push_item(KIND_BYTE, 8'h00, 0, 1'b0);
      push_item(KIND_BYTE, 8'hFF, 1, 1'b0);
      push_item(KIND_BYTE, 8'h41, 0, 1'b0);
      push_item(KIND_BYTE, BYTE_DEL, 0, 1'b0);
      push_item(KIND_BYTE, BYTE_BS, 2, 1'b0);
      push_item(KIND_BYTE, 8'h7E, 0, 1'b0);
      push_item(KIND_BYTE, BYTE_CR, 0, 1'b0);
      push_item(KIND_TAKE, 8'hFF, 0, 1'b0);      // read out a two-byte line
      push_item(KIND_TAKE, 8'h00, 0, 1'b0);
      push_item(KIND_BYTE, BYTE_CR, 0, 1'b0);    // commit an empty line
      push_item(KIND_BYTE, 8'h55, 0, 1'b0);
      push_item(KIND_BYTE, BYTE_CR, 3, 1'b0);    // carriage return while a line waits
      push_item(KIND_TAKE, 8'h00, 0, 1'b0);      // empty held line
      push_item(KIND_TAKE, 8'h00, 0, 1'b0);
      push_item(KIND_BYTE, 8'h80, 0, 1'b1);      // sender waits for everything owed
      push_item(KIND_BYTE, BYTE_CR, 0, 1'b0);
      push_item(KIND_TAKE, BYTE_CR, 0, 1'b0);

      // Random part: mostly well-formed lines, one overlong line, some noise.
      n_rand = 0;
      long_sent = 1'b0;
      while (n_rand < 88) begin
         r = $urandom_range(0, 99);
         if (!long_sent && n_rand >= 10) begin
            // Overfill the line with no sender gaps, erase one, refill, commit, take.
            long_sent = 1'b1;
            for (i = 0; i < LINE_LEN + 2; i++) begin
               push_item(KIND_BYTE, plain_byte(), 0, 1'b0);
            end
            push_item(KIND_BYTE, BYTE_DEL, 0, 1'b0);
            push_item(KIND_BYTE, plain_byte(), 0, 1'b0);
            push_item(KIND_BYTE, BYTE_CR, 0, 1'b0);
            push_item(KIND_TAKE, 8'($urandom_range(0, 255)), 0, 1'b0);
            n_rand += LINE_LEN + 6;
         end else if (r < 70) begin
            len = $urandom_range(0, 8);
            for (i = 0; i < len; i++) begin
               if ($urandom_range(0, 99) < 15) begin
                  push_item(KIND_BYTE, ($urandom_range(0, 1) != 0) ? BYTE_BS : BYTE_DEL,
                     pick_gap(), 1'b0);
               end else begin
                  push_item(KIND_BYTE, plain_byte(), pick_gap(), 1'b0);
               end
               n_rand++;
            end
            push_item(KIND_BYTE, BYTE_CR, pick_gap(), 1'b0);
            n_rand++;
            if ($urandom_range(0, 99) < 75) begin
               push_item(KIND_TAKE, 8'($urandom_range(0, 255)), pick_gap(),
                  $urandom_range(0, 99) < 10);
               n_rand++;
            end
         end else begin
            push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), pick_gap(), 1'b0);
            n_rand++;
         end
      end
      n_total = typed_q.size();

      // Wrap-up once every item is taken and every response is in.
      @(negedge clock);
      while (n_req_acc < n_total || due_rsp.size() != 0 || quiet < 20) begin
         @(posedge clock);
      end
      $display("Run covered %0d request items including %0d takes, checking %0d responses.",
         n_req_acc, n_takes, n_rsp_acc);
      $display("It read out %0d held lines, echoed %0d erases and dropped %0d bytes %s",
         n_lines_out, n_erases, n_dropped, "on a full line.");
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5000000;
      $display("Timeout: %0d responses still owed", due_rsp.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
